@@ rtl/nrte_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC time extractor package
// Constants, parse phase type and small decode functions for the RMC
// sentence parser.
// ----------------------------------------------------------------------------
package nrte_pkg;

   localparam int MAX_SENTENCE_LEN = 1024;
   localparam int POS_WIDTH        = $clog2(MAX_SENTENCE_LEN + 1);
   localparam int HEADER_LEN       = 6;
   localparam int TIME_FIRST_POS   = 7;
   localparam int TIME_DIGITS      = 6;
   localparam int HOURS_PER_DAY    = 24;
   localparam int HOUR_SUB_STEPS   = 5;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int ZONE_WIDTH     = 5;
   localparam logic [ZONE_WIDTH-1:0] ZONE_RESET = 5'd8;
   localparam logic CSR_ZONE_INDEX = 1'b0;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   typedef enum logic [2:0] {
      PH_SEEK_COMMA,
      PH_STATUS_NEXT,
      PH_PRE_STAR,
      PH_HEX_HIGH,
      PH_HEX_LOW,
      PH_TRAILER
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic logic [7:0] header_char(input logic [2:0] index);
      logic [7:0] c;
      unique case (index)
         3'd0: c = CHAR_DOLLAR;
         3'd1: c = 8'h47;
         3'd2: c = 8'h50;
         3'd3: c = 8'h52;
         3'd4: c = 8'h4D;
         3'd5: c = 8'h43;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic hex_type hex_digit(input logic [7:0] b);
      hex_type h;
      h.valid = 1'b0;
      h.value = 4'd0;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         h.valid = 1'b1;
         h.value = b[3:0];
      end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) begin
         h.valid = 1'b1;
         h.value = 4'(b[3:0] + 4'd9);
      end
      return h;
   endfunction

   function automatic logic [6:0] two_digits(input logic [3:0] tens, input logic [3:0] ones);
      logic [6:0] v;
      v = 7'({tens, 3'b000}) + 7'({tens, 1'b0}) + 7'(ones);
      return v;
   endfunction

   function automatic logic [4:0] hour_mod24(input logic [7:0] v);
      logic [7:0] r;
      r = v;
      for (int k = 0; k < HOUR_SUB_STEPS; k++) begin
         if (r >= 8'(HOURS_PER_DAY)) begin
            r = r - 8'(HOURS_PER_DAY);
         end
      end
      return r[4:0];
   endfunction

endpackage

@@ rtl/nmea_rmc_time_extractor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC time extractor
// Parses a byte stream of NMEA sentences and reports the local time of the
// last valid RMC sentence at the end of every sentence.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle unless it stalls. Each accepted byte
// goes into an input register, is parsed in one pass against the running
// sentence state, and a space, CR or LF that ends a non-empty sentence loads the
// result register when the byte leaves the input register. Throughput is set by
// the single parse stage and is one byte per cycle while the result side takes
// its items; a held result stalls only a sentence end that needs the result
// register.
module nmea_rmc_time_extractor (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_sentence_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [4:0]                         rsp_hours,
   output logic [6:0]                         rsp_minutes,
   output logic [6:0]                         rsp_seconds,
   output logic                               rsp_updated,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [nrte_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [nrte_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [nrte_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);
   import nrte_pkg::*;

   logic                  zone_write;
   logic [ZONE_WIDTH-1:0] zone_offset_ff;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff;
   logic       accept, advance, out_free, emit, ok, is_delim;

   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   phase_type            phase_ff, phase_in;
   logic [7:0]           xor_ff, xor_in;
   logic [7:0]           chk_ff, chk_in;
   logic [3:0]           digits_ff [TIME_DIGITS];
   logic [3:0]           digits_in [TIME_DIGITS];
   logic                 status_ok_ff, status_ok_in;
   logic                 error_ff, error_in;

   logic [4:0] held_hours_ff, held_hours_in;
   logic [6:0] held_minutes_ff, held_minutes_in;
   logic [6:0] held_seconds_ff, held_seconds_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [4:0] rsp_hours_ff;
   logic [6:0] rsp_minutes_ff;
   logic [6:0] rsp_seconds_ff;
   logic       rsp_updated_ff;

   hex_type    hex;
   logic [6:0] utc_hours;

   assign zone_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CSR_ZONE_INDEX);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_ZONE_INDEX)
                       ? CSR_DATA_WIDTH'(zone_offset_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_offset_ff <= ZONE_RESET;
      end else if (zone_write) begin
         zone_offset_ff <= csr_pwdata[ZONE_WIDTH-1:0];
      end
   end

   // Handshake between the input register and the result register.
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign advance     = in_valid_ff && (!emit || out_free);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_sentence_byte;
      end
   end

   assign hex       = hex_digit(byte_ff);
   assign utc_hours = two_digits(digits_ff[0], digits_ff[1]);

   always_comb begin
      pos_in          = pos_ff;
      phase_in        = phase_ff;
      xor_in          = xor_ff;
      chk_in          = chk_ff;
      digits_in       = digits_ff;
      status_ok_in    = status_ok_ff;
      error_in        = error_ff;
      held_hours_in   = held_hours_ff;
      held_minutes_in = held_minutes_ff;
      held_seconds_in = held_seconds_ff;
      emit            = 1'b0;
      ok              = 1'b0;
      is_delim        = (byte_ff == CHAR_SPACE) || (byte_ff == CHAR_CR)
                        || (byte_ff == CHAR_LF);
      if (in_valid_ff) begin
         if (is_delim) begin
            if (pos_ff != '0) begin
               emit = 1'b1;
               ok   = (phase_ff == PH_TRAILER) && status_ok_ff && !error_ff
                      && (xor_ff == chk_ff);
               if (ok) begin
                  held_hours_in   = hour_mod24(8'(utc_hours) + 8'(zone_offset_ff));
                  held_minutes_in = two_digits(digits_ff[2], digits_ff[3]);
                  held_seconds_in = two_digits(digits_ff[4], digits_ff[5]);
               end
               pos_in       = '0;
               phase_in     = PH_SEEK_COMMA;
               xor_in       = '0;
               chk_in       = '0;
               status_ok_in = 1'b0;
               error_in     = 1'b0;
               for (int k = 0; k < TIME_DIGITS; k++) begin
                  digits_in[k] = '0;
               end
            end
         end else begin
            if (pos_ff >= POS_WIDTH'(MAX_SENTENCE_LEN)) begin
               error_in = 1'b1;
            end
            if (pos_ff < POS_WIDTH'(HEADER_LEN) && byte_ff != header_char(pos_ff[2:0])) begin
               error_in = 1'b1;
            end
            for (int k = 0; k < TIME_DIGITS; k++) begin
               if (pos_ff == POS_WIDTH'(TIME_FIRST_POS + k)) begin
                  if (byte_ff >= CHAR_ZERO && byte_ff <= CHAR_NINE) begin
                     digits_in[k] = byte_ff[3:0];
                  end else begin
                     error_in = 1'b1;
                  end
               end
            end
            unique case (phase_ff) inside
               PH_SEEK_COMMA, PH_STATUS_NEXT, PH_PRE_STAR: begin
                  if (phase_ff == PH_STATUS_NEXT) begin
                     if (byte_ff == CHAR_UPPER_A) begin
                        status_ok_in = 1'b1;
                     end
                     phase_in = PH_PRE_STAR;
                  end else if (phase_ff == PH_SEEK_COMMA
                               && pos_ff >= POS_WIDTH'(TIME_FIRST_POS)
                               && byte_ff == CHAR_COMMA) begin
                     phase_in = PH_STATUS_NEXT;
                  end
                  if (byte_ff == CHAR_STAR) begin
                     phase_in = PH_HEX_HIGH;
                  end else if (pos_ff != '0) begin
                     xor_in = xor_ff ^ byte_ff;
                  end
               end
               PH_HEX_HIGH, PH_HEX_LOW: begin
                  if (hex.valid) begin
                     chk_in = {chk_ff[3:0], hex.value};
                  end else begin
                     error_in = 1'b1;
                  end
                  phase_in = (phase_ff == PH_HEX_HIGH) ? PH_HEX_LOW : PH_TRAILER;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
            if (pos_ff < POS_WIDTH'(MAX_SENTENCE_LEN)) begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= '0;
         phase_ff        <= PH_SEEK_COMMA;
         xor_ff          <= '0;
         chk_ff          <= '0;
         status_ok_ff    <= 1'b0;
         error_ff        <= 1'b0;
         held_hours_ff   <= '0;
         held_minutes_ff <= '0;
         held_seconds_ff <= '0;
         for (int k = 0; k < TIME_DIGITS; k++) begin
            digits_ff[k] <= '0;
         end
      end else if (advance) begin
         pos_ff          <= pos_in;
         phase_ff        <= phase_in;
         xor_ff          <= xor_in;
         chk_ff          <= chk_in;
         status_ok_ff    <= status_ok_in;
         error_ff        <= error_in;
         held_hours_ff   <= held_hours_in;
         held_minutes_ff <= held_minutes_in;
         held_seconds_ff <= held_seconds_in;
         digits_ff       <= digits_in;
      end
   end

   assign rsp_valid_in = (advance && emit) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_hours_ff   <= held_hours_in;
         rsp_minutes_ff <= held_minutes_in;
         rsp_seconds_ff <= held_seconds_in;
         rsp_updated_ff <= ok;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hours   = rsp_hours_ff;
   assign rsp_minutes = rsp_minutes_ff;
   assign rsp_seconds = rsp_seconds_ff;
   assign rsp_updated = rsp_updated_ff;

   a_hours_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hours_ff < 5'(HOURS_PER_DAY)))
      else $error("Result hour is out of range.");

   a_phase_needs_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_SEEK_COMMA) |-> (pos_ff != '0))
      else $error("Parse phase moved without any byte of the sentence.");

   a_status_after_comma: assert property (@(posedge clock) disable iff (reset)
      status_ok_ff |-> (phase_ff != PH_SEEK_COMMA && phase_ff != PH_STATUS_NEXT))
      else $error("Status flag set before the status field was seen.");

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_WIDTH'(MAX_SENTENCE_LEN))
      else $error("Byte position passed its saturation value.");

   a_emit_loads_result: assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |=> rsp_valid_ff)
      else $error("A sentence end did not produce a result item.");

endmodule

@@ test/nrte_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC time extractor checker
// Watches the byte channel, the result channel and the register port of the
// time extractor. It keeps its own copy of the sentence parse state and of
// the zone offset, works out the result of each sentence end, and compares
// every result item against the oldest expected one.
// ----------------------------------------------------------------------------
module nrte_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [7:0]                          req_sentence_byte,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [4:0]                          rsp_hours,
   input  logic [6:0]                          rsp_minutes,
   input  logic [6:0]                          rsp_seconds,
   input  logic                                rsp_updated,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [nrte_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [nrte_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic                                csr_pready,
   output int                                  mismatches,
   output int                                  pending
);
   import nrte_pkg::*;

   localparam logic [47:0] RMC_TAG = "$GPRMC";
   localparam logic [CSR_ADDR_WIDTH-1:0] ZONE_ADDR = CSR_ADDR_WIDTH'({CSR_ZONE_INDEX, 2'b00});

   typedef struct packed {
      logic [4:0] hours;
      logic [6:0] minutes;
      logic [6:0] seconds;
      logic       updated;
   } clock_reading_type;

   clock_reading_type readings_q[$];
   clock_reading_type want;
   int                fail_count = 0;

   logic [ZONE_WIDTH-1:0] zone_hours;
   int                    byte_pos;
   phase_type             phase;
   logic [7:0]            running_xor;
   logic [7:0]            sent_sum;
   logic [3:0]            digit_buf [TIME_DIGITS];
   logic                  status_ok;
   logic                  broken;
   logic [4:0]            held_hours;
   logic [6:0]            held_minutes;
   logic [6:0]            held_seconds;

   function automatic int hex_nibble(input logic [7:0] b);
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         return int'(b - CHAR_ZERO);
      end
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) begin
         return int'(b - CHAR_UPPER_A) + 10;
      end
      return -1;
   endfunction

   function automatic void clear_sentence();
      byte_pos = 0;
      phase = PH_SEEK_COMMA;
      running_xor = '0;
      sent_sum = '0;
      for (int k = 0; k < TIME_DIGITS; k++) begin
         digit_buf[k] = '0;
      end
      status_ok = 1'b0;
      broken = 1'b0;
   endfunction

   function automatic void take_byte(input logic [7:0] b);
      int                nib;
      logic              accept;
      clock_reading_type entry;
      if (b == CHAR_SPACE || b == CHAR_CR || b == CHAR_LF) begin
         if (byte_pos != 0) begin
            accept = phase == PH_TRAILER && status_ok && !broken
                     && running_xor == sent_sum;
            if (accept) begin
               held_hours = 5'((digit_buf[0] * 10 + digit_buf[1] + zone_hours) % HOURS_PER_DAY);
               held_minutes = 7'(digit_buf[2] * 10 + digit_buf[3]);
               held_seconds = 7'(digit_buf[4] * 10 + digit_buf[5]);
            end
            entry.hours = held_hours;
            entry.minutes = held_minutes;
            entry.seconds = held_seconds;
            entry.updated = accept;
            readings_q.push_back(entry);
            clear_sentence();
         end
         return;
      end
      if (byte_pos >= MAX_SENTENCE_LEN) begin
         broken = 1'b1;
      end
      if (byte_pos < HEADER_LEN && b != RMC_TAG[8 * (HEADER_LEN - 1 - byte_pos) +: 8]) begin
         broken = 1'b1;
      end
      if (byte_pos >= TIME_FIRST_POS && byte_pos < TIME_FIRST_POS + TIME_DIGITS) begin
         if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            digit_buf[byte_pos - TIME_FIRST_POS] = b[3:0];
         end else begin
            broken = 1'b1;
         end
      end
      if (phase == PH_SEEK_COMMA || phase == PH_STATUS_NEXT || phase == PH_PRE_STAR) begin
         if (phase == PH_STATUS_NEXT) begin
            if (b == CHAR_UPPER_A) begin
               status_ok = 1'b1;
            end
            phase = PH_PRE_STAR;
         end else if (phase == PH_SEEK_COMMA && byte_pos >= TIME_FIRST_POS &&
                      b == CHAR_COMMA) begin
            phase = PH_STATUS_NEXT;
         end
         if (b == CHAR_STAR) begin
            phase = PH_HEX_HIGH;
         end else if (byte_pos >= 1) begin
            running_xor ^= b;
         end
      end else if (phase == PH_HEX_HIGH || phase == PH_HEX_LOW) begin
         nib = hex_nibble(b);
         if (nib < 0) begin
            broken = 1'b1;
         end else begin
            sent_sum = {sent_sum[3:0], 4'(nib)};
         end
         phase = (phase == PH_HEX_HIGH) ? PH_HEX_LOW : PH_TRAILER;
      end
      if (byte_pos <= MAX_SENTENCE_LEN) begin
         byte_pos++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_sentence();
         zone_hours = ZONE_RESET;
         held_hours = '0;
         held_minutes = '0;
         held_seconds = '0;
         readings_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == ZONE_ADDR) begin
            zone_hours = csr_pwdata[ZONE_WIDTH-1:0];
         end
         if (req_valid && !req_stall) begin
            take_byte(req_sentence_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (readings_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("unexpected result item: %0d:%0d:%0d updated=%0b",
                           rsp_hours, rsp_minutes, rsp_seconds, rsp_updated);
               end
            end else begin
               want = readings_q.pop_front();
               if (rsp_hours !== want.hours || rsp_minutes !== want.minutes ||
                   rsp_seconds !== want.seconds || rsp_updated !== want.updated) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display({"result mismatch: expected %0d:%0d:%0d updated=%0b, ",
                               "got %0d:%0d:%0d updated=%0b"},
                              want.hours, want.minutes, want.seconds, want.updated,
                              rsp_hours, rsp_minutes, rsp_seconds, rsp_updated);
                  end
               end
            end
         end
      end
      mismatches <= fail_count;
      pending <= readings_q.size();
   end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC time extractor testbench
// Feeds the time extractor with directed and random NMEA sentences, good and
// broken, under several zone offsets and several patterns of idle and stall
// on both channels. The checker beside the block predicts and compares the
// results; this module makes the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import nrte_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 300;
   localparam int RANDOM_BYTES   = 1000;
   localparam int MIN_SENTENCES  = 48;
   localparam int PHASES         = 4;
   localparam logic [47:0] RMC_TAG = "$GPRMC";
   localparam logic [CSR_ADDR_WIDTH-1:0] ZONE_ADDR = CSR_ADDR_WIDTH'({CSR_ZONE_INDEX, 2'b00});

   typedef enum {
      FORM_GOOD,
      FORM_BAD_SUM,
      FORM_BAD_DIGIT,
      FORM_BAD_HEADER,
      FORM_NO_STAR,
      FORM_BAD_HEX,
      FORM_NO_STATUS,
      FORM_VOID,
      FORM_LONG,
      FORM_NOISE,
      FORM_EMPTY
   } line_form_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_sentence_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [4:0]                rsp_hours;
   logic [6:0]                rsp_minutes;
   logic [6:0]                rsp_seconds;
   logic                      rsp_updated;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   int mismatches;
   int pending;
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int sent_bytes = 0;
   int sent_lines = 0;
   logic [7:0] line_q[$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   nmea_rmc_time_extractor uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sentence_byte (req_sentence_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hours         (rsp_hours),
      .rsp_minutes       (rsp_minutes),
      .rsp_seconds       (rsp_seconds),
      .rsp_updated       (rsp_updated),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   nrte_checker nrte_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sentence_byte (req_sentence_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hours         (rsp_hours),
      .rsp_minutes       (rsp_minutes),
      .rsp_seconds       (rsp_seconds),
      .rsp_updated       (rsp_updated),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .mismatches        (mismatches),
      .pending           (pending)
   );

   // The long hold-off is counted here so that the sender keeps offering
   // bytes while the result side is blocked.
   always @(posedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("FAIL nmea_rmc_time_extractor");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] filler_byte();
      logic [7:0] b;
      if ($urandom_range(0, 7) == 0) begin
         return 8'h00;
      end
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == CHAR_SPACE || b == CHAR_CR || b == CHAR_LF || b == CHAR_STAR ||
                 b == CHAR_COMMA);
      return b;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return (n < 10) ? CHAR_ZERO + 8'(n) : CHAR_UPPER_A + 8'(n) - 8'd10;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sentence_byte <= b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sent_bytes++;
   endtask

   task automatic send_sentence(input line_form_type form, input int stamp);
      logic [7:0] sum;
      int         spot;
      line_q.delete();
      if (form == FORM_NOISE) begin
         repeat ($urandom_range(1, 30)) begin
            line_q.push_back(8'($urandom_range(0, 255)));
         end
      end else if (form != FORM_EMPTY) begin
         for (int k = 0; k < HEADER_LEN; k++) begin
            line_q.push_back(RMC_TAG[8 * (HEADER_LEN - 1 - k) +: 8]);
         end
         if (form == FORM_BAD_HEADER) begin
            spot = $urandom_range(0, HEADER_LEN - 1);
            line_q[spot] = line_q[spot] + 8'd1;
         end
         line_q.push_back(($urandom_range(0, 3) == 0) ? filler_byte() : CHAR_COMMA);
         for (int k = 0; k < TIME_DIGITS; k++) begin
            line_q.push_back(CHAR_ZERO + 8'((stamp / 10 ** (TIME_DIGITS - 1 - k)) % 10));
         end
         if (form == FORM_BAD_DIGIT) begin
            spot = TIME_FIRST_POS + $urandom_range(0, TIME_DIGITS - 1);
            do begin
               line_q[spot] = filler_byte();
            end while (line_q[spot] >= CHAR_ZERO && line_q[spot] <= CHAR_NINE);
         end
         if ($urandom_range(0, 1) == 1) begin
            line_q.push_back(".");
            line_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            line_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
         end
         if (form != FORM_NO_STATUS) begin
            line_q.push_back(CHAR_COMMA);
            line_q.push_back((form == FORM_VOID) ? "V" : CHAR_UPPER_A);
         end
         repeat ($urandom_range(0, 4)) begin
            if (form != FORM_NO_STATUS) begin
               line_q.push_back(CHAR_COMMA);
            end
            repeat ($urandom_range(0, 4)) begin
               line_q.push_back(filler_byte());
            end
         end
         if (form == FORM_LONG) begin
            repeat (MAX_SENTENCE_LEN + 16) begin
               line_q.push_back(filler_byte());
            end
         end
         if (form != FORM_NO_STAR) begin
            sum = '0;
            for (int k = 1; k < line_q.size(); k++) begin
               sum ^= line_q[k];
            end
            if (form == FORM_BAD_SUM) begin
               sum ^= 8'(1 << $urandom_range(0, 7));
            end
            line_q.push_back(CHAR_STAR);
            line_q.push_back(hex_char(sum[7:4]));
            line_q.push_back(hex_char(sum[3:0]));
            if (form == FORM_BAD_HEX) begin
               spot = line_q.size() - 1 - $urandom_range(0, 1);
               line_q[spot] = "a" + 8'($urandom_range(0, 5));
            end
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 3)) begin
                  line_q.push_back(filler_byte());
               end
            end
         end
      end
      case ($urandom_range(0, 2))
         0: line_q.push_back(CHAR_SPACE);
         1: line_q.push_back(CHAR_CR);
         default: line_q.push_back(CHAR_LF);
      endcase
      foreach (line_q[k]) begin
         send_byte(line_q[k]);
      end
      sent_lines++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_zone(input logic [ZONE_WIDTH-1:0] hours);
      drain();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ZONE_ADDR;
      csr_pwdata <= {(CSR_DATA_WIDTH - ZONE_WIDTH)'($urandom), hours};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   initial begin
      line_form_type form;
      int            pick;
      int            phase_bytes;
      int            phase_lines;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_sentence(FORM_GOOD, 235959);
      send_sentence(FORM_GOOD, 0);
      send_sentence(FORM_GOOD, 999999);
      send_sentence(FORM_EMPTY, 0);
      send_sentence(FORM_VOID, 120000);
      send_sentence(FORM_NO_STAR, 123456);
      send_sentence(FORM_BAD_DIGIT, 101010);
      send_sentence(FORM_BAD_HEX, 111111);
      send_sentence(FORM_BAD_SUM, 222222);
      send_sentence(FORM_NO_STATUS, 30303);
      send_sentence(FORM_BAD_HEADER, 40404);
      send_sentence(FORM_LONG, 50505);
      send_sentence(FORM_NOISE, 0);
      write_zone(5'd0);
      send_sentence(FORM_GOOD, 235959);
      write_zone(5'd23);
      send_sentence(FORM_GOOD, 10000);
      write_zone(5'd31);
      send_sentence(FORM_GOOD, 995959);

      for (int ph = 0; ph < PHASES; ph++) begin
         write_zone(5'($urandom_range(0, 31)));
         idle_pct = (ph == 1) ? 83 : (ph == 3) ? 13 : 0;
         stall_pct <= (ph == 2) ? 83 : (ph == 3) ? 13 : 0;
         phase_bytes = sent_bytes;
         phase_lines = sent_lines;
         while (sent_bytes - phase_bytes < RANDOM_BYTES / PHASES ||
                sent_lines - phase_lines < MIN_SENTENCES / PHASES) begin
            if (ph == 0 && sent_lines - phase_lines == 3) begin
               hold_requests <= hold_requests + 1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) form = FORM_GOOD;
            else if (pick < 65) form = FORM_BAD_SUM;
            else if (pick < 69) form = FORM_BAD_DIGIT;
            else if (pick < 73) form = FORM_BAD_HEADER;
            else if (pick < 77) form = FORM_NO_STAR;
            else if (pick < 81) form = FORM_BAD_HEX;
            else if (pick < 85) form = FORM_NO_STATUS;
            else if (pick < 89) form = FORM_VOID;
            else if (pick < 94) form = FORM_NOISE;
            else if (pick < 99) form = FORM_EMPTY;
            else form = FORM_LONG;
            send_sentence(form, $urandom_range(0, 999999));
         end
      end

      drain();
      if (mismatches == 0 && pending == 0) begin
         $display("PASS nmea_rmc_time_extractor");
      end else begin
         $display("FAIL nmea_rmc_time_extractor");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/nrte_pkg.sv
rtl/nmea_rmc_time_extractor.sv
test/nrte_checker.sv
test/tb_top.sv
